// File: sv/arrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrt_pkg
// Shared types and constants for the address range reservation table.
// ----------------------------------------------------------------------------
package arrt_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int ADDR_WIDTH_DEF = 32;

  localparam logic [15:0] IO_POOL_LAST = 16'hFFFF;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 8;
  localparam int FIELD_W    = 32;
  localparam int HANDLE_W   = 4;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FIND    = 2'd2,
    OP_RSVD    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_CONFLICT  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_END,
    S_DONE
  } state_t;

  // per-slot compare outcome
  typedef struct packed {
    logic overlap;
    logic exact;
    logic free;
  } cmp_res_t;

  // table update strobes
  typedef struct packed {
    logic set;
    logic clear;
  } wr_ctl_t;

endpackage

// File: sv/address_range_reservation_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_reservation_table_unit
// Reserves, releases and looks up address ranges in an I/O and a memory pool.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per command. in_tuser = {pool_select, opcode},
//           in_tdata = {range_count, range_start}.
//   out_* : one response per request, out_tdata = {pad, handle, status}.
//   A request is answered on out_tvalid after a scan of all slots, or without
//   a scan when rejected as invalid up front. The scan reads one slot per cycle
//   through the single read port of the slot memory and one shared comparator.
//   in_tready is high only while no request is in progress, so a new request
//   is taken only after the previous one has finished.
//   A finished response sits in an output register; the next request can be
//   taken while it waits. If the receiver stalls and a second response is
//   ready, the unit holds it until the output register frees up.
//   Reset clears all slot valid bits, so the table starts empty; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module address_range_reservation_table_unit #(
  parameter int ENTRIES    = arrt_pkg::ENTRIES_DEF,
  parameter int ADDR_WIDTH = arrt_pkg::ADDR_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [arrt_pkg::IN_DATA_W-1:0]  in_tdata,  // range_start, range_count
  input  logic [arrt_pkg::IN_USER_W-1:0]  in_tuser,  // opcode, pool_select
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [arrt_pkg::OUT_DATA_W-1:0] out_tdata  // status, slot_handle, pad
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [ADDR_WIDTH-1:0] IO_LAST = ADDR_WIDTH'(arrt_pkg::IO_POOL_LAST);
  localparam int FW = arrt_pkg::FIELD_W;

  arrt_pkg::state_t  state_r, state_nxt;
  arrt_pkg::opcode_t op_r;
  logic                  pool_r;
  logic [ADDR_WIDTH-1:0] first_r;
  logic [ADDR_WIDTH-1:0] count_r;
  logic [ADDR_WIDTH-1:0] last_r;
  logic                  invalid_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  cmp_vld_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic                  conflict_r;
  logic                  found_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic                  out_tvalid_r;
  logic [arrt_pkg::OUT_DATA_W-1:0] out_tdata_r;

  logic                  in_acc;
  logic                  out_free;
  logic [ADDR_WIDTH:0]   end_sum;
  logic [ADDR_WIDTH-1:0] last_w;
  logic                  bad_w;
  logic                  rd_en;
  logic                  leave_done;
  arrt_pkg::wr_ctl_t     wr_ctl;
  logic [IDX_W-1:0]      wr_idx;
  arrt_pkg::status_t     status_w;
  logic [IDX_W-1:0]      handle_w;
  arrt_pkg::cmp_res_t    cmp_res;
  logic                  slot_vld;
  logic                  slot_pool;
  logic [ADDR_WIDTH-1:0] slot_first;
  logic [ADDR_WIDTH-1:0] slot_last;

  assign in_tready  = (state_r == arrt_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // end address and up-front range checks
  assign end_sum = {1'b0, first_r} + {1'b0, count_r} - {{ADDR_WIDTH{1'b0}}, 1'b1};
  assign last_w  = end_sum[ADDR_WIDTH-1:0];
  assign bad_w   = (op_r == arrt_pkg::OP_RSVD) || (count_r == '0) || end_sum[ADDR_WIDTH] ||
                   ((op_r == arrt_pkg::OP_REQUEST) && !pool_r && (last_w > IO_LAST));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arrt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rd_en      = 1'b0;
    leave_done = 1'b0;
    unique case (state_r)
      arrt_pkg::S_IDLE: begin
        if (in_acc) state_nxt = arrt_pkg::S_PREP;
      end
      arrt_pkg::S_PREP: begin
        state_nxt = bad_w ? arrt_pkg::S_DONE : arrt_pkg::S_SCAN;
      end
      arrt_pkg::S_SCAN: begin
        rd_en = 1'b1;
        if (idx_r == LAST_IDX) state_nxt = arrt_pkg::S_END;
      end
      arrt_pkg::S_END: begin
        state_nxt = arrt_pkg::S_DONE;
      end
      arrt_pkg::S_DONE: begin
        if (out_free) begin
          leave_done = 1'b1;
          state_nxt  = arrt_pkg::S_IDLE;
        end
      end
      default: state_nxt = arrt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= arrt_pkg::opcode_t'(in_tuser[1:0]);
      pool_r  <= in_tuser[2];
      first_r <= ADDR_WIDTH'(in_tdata[FW-1:0]);
      count_r <= ADDR_WIDTH'(in_tdata[2*FW-1:FW]);
    end
    if (state_r == arrt_pkg::S_PREP) begin
      last_r    <= last_w;
      invalid_r <= bad_w;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == arrt_pkg::S_PREP) begin
      idx_r <= '0;
    end else if (rd_en) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    cmp_idx_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= rd_en;
    end
  end

  // accumulate over the scan; lowest index wins for hit and free slot
  always_ff @(posedge clk) begin
    if (state_r == arrt_pkg::S_PREP) begin
      conflict_r   <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      hit_idx_r    <= '0;
      free_idx_r   <= '0;
    end else if (cmp_vld_r) begin
      if (cmp_res.overlap) conflict_r <= 1'b1;
      if (cmp_res.exact && !found_r) begin
        found_r   <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
      if (cmp_res.free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
    end
  end

  always_comb begin
    status_w = arrt_pkg::ST_OK;
    handle_w = '0;
    if (invalid_r) begin
      status_w = arrt_pkg::ST_INVALID;
    end else if (op_r == arrt_pkg::OP_REQUEST) begin
      if (conflict_r) begin
        status_w = arrt_pkg::ST_CONFLICT;
      end else if (!free_found_r) begin
        status_w = arrt_pkg::ST_FULL;
      end else begin
        handle_w = free_idx_r;
      end
    end else if (found_r) begin
      handle_w = hit_idx_r;
    end else begin
      status_w = arrt_pkg::ST_NOT_FOUND;
    end
  end

  assign wr_ctl.set   = leave_done && !invalid_r && (op_r == arrt_pkg::OP_REQUEST) &&
                        !conflict_r && free_found_r;
  assign wr_ctl.clear = leave_done && !invalid_r && (op_r == arrt_pkg::OP_RELEASE) && found_r;
  assign wr_idx       = wr_ctl.set ? free_idx_r : hit_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (leave_done) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (leave_done) begin
      out_tdata_r <= {1'b0, arrt_pkg::HANDLE_W'(handle_w), status_w};
    end
  end

  arrt_slot_store #(
    .ENTRIES    (ENTRIES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (rd_en),
    .rd_idx     (idx_r),
    .wr_ctl     (wr_ctl),
    .wr_idx     (wr_idx),
    .wr_pool    (pool_r),
    .wr_first   (first_r),
    .wr_last    (last_r),
    .rd_vld_r   (slot_vld),
    .rd_pool_r  (slot_pool),
    .rd_first_r (slot_first),
    .rd_last_r  (slot_last)
  );

  arrt_cmp_unit #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_cmp (
    .req_pool   (pool_r),
    .req_first  (first_r),
    .req_last   (last_r),
    .slot_vld   (slot_vld),
    .slot_pool  (slot_pool),
    .slot_first (slot_first),
    .slot_last  (slot_last),
    .res        (cmp_res)
  );

`ifndef SYNTHESIS
  a_done_gives_resp: assert property (@(posedge clk) disable iff (!rst_n)
    leave_done |=> out_tvalid)
    else $error("response not presented after completion");

  a_end_sees_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arrt_pkg::S_END) |-> (cmp_vld_r && (cmp_idx_r == LAST_IDX)))
    else $error("scan ended before last slot compared");

  a_cmp_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> ((state_r == arrt_pkg::S_SCAN) || (state_r == arrt_pkg::S_END)))
    else $error("compare result outside scan");

  a_set_only_clean: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ctl.set |-> (!conflict_r && free_found_r && !wr_ctl.clear))
    else $error("slot written on conflicting or full request");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arrt_pkg::S_SCAN) |=> !in_tready)
    else $error("request taken during scan");
`endif

endmodule

// File: sv/arrt_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrt_slot_store
// Slot table: valid flops plus a one-write, one-read memory of pool and bounds.
// ----------------------------------------------------------------------------
module arrt_slot_store #(
  parameter int ENTRIES    = arrt_pkg::ENTRIES_DEF,
  parameter int ADDR_WIDTH = arrt_pkg::ADDR_WIDTH_DEF,
  localparam int IDX_W     = $clog2(ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_idx,
  input  arrt_pkg::wr_ctl_t     wr_ctl,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic                  wr_pool,
  input  logic [ADDR_WIDTH-1:0] wr_first,
  input  logic [ADDR_WIDTH-1:0] wr_last,
  output logic                  rd_vld_r,
  output logic                  rd_pool_r,
  output logic [ADDR_WIDTH-1:0] rd_first_r,
  output logic [ADDR_WIDTH-1:0] rd_last_r
);

  localparam int ROW_W = 2 * ADDR_WIDTH + 1;

  logic [ROW_W-1:0]   mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ctl.set) begin
      vld_r[wr_idx] <= 1'b1;
    end else if (wr_ctl.clear) begin
      vld_r[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.set) begin
      mem[wr_idx] <= {wr_pool, wr_first, wr_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_pool_r, rd_first_r, rd_last_r} <= mem[rd_idx];
      rd_vld_r                           <= vld_r[rd_idx];
    end
  end

endmodule

// File: sv/arrt_cmp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrt_cmp_unit
// Shared slot comparator: overlap, exact match and free test for one slot.
// ----------------------------------------------------------------------------
module arrt_cmp_unit #(
  parameter int ADDR_WIDTH = arrt_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  req_pool,
  input  logic [ADDR_WIDTH-1:0] req_first,
  input  logic [ADDR_WIDTH-1:0] req_last,
  input  logic                  slot_vld,
  input  logic                  slot_pool,
  input  logic [ADDR_WIDTH-1:0] slot_first,
  input  logic [ADDR_WIDTH-1:0] slot_last,
  output arrt_pkg::cmp_res_t    res
);

  logic same_pool;
  logic below;
  logic above;

  assign same_pool   = slot_vld && (slot_pool == req_pool);
  assign below       = req_last < slot_first;
  assign above       = req_first > slot_last;
  assign res.overlap = same_pool && !below && !above;
  assign res.exact   = same_pool && (req_first == slot_first) && (req_last == slot_last);
  assign res.free    = !slot_vld;

endmodule

// File: verif/range_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_table_checker
// Watches the request and response streams of the reservation table, keeps
// its own copy of the slot table, predicts the status and handle of every
// accepted request and compares each accepted response with the oldest
// prediction.
// ----------------------------------------------------------------------------
module range_table_checker
  import arrt_pkg::*;
#(
  parameter int SLOTS = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // range_start, range_count
  input  logic [IN_USER_W-1:0]  in_tuser,   // opcode, pool_select
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // status, slot_handle, pad
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
  } response_t;

  logic                slot_held  [SLOTS];
  logic                slot_pool  [SLOTS];
  logic [FIELD_W-1:0]  slot_first [SLOTS];
  logic [FIELD_W-1:0]  slot_last  [SLOTS];

  response_t expected_responses[$];

  task automatic report_mismatch(input string msg);
    $display("range_table_checker: %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic response_t predict_reservation(input opcode_t op, input logic pool,
                                                    input logic [FIELD_W-1:0] first,
                                                    input logic [FIELD_W-1:0] count);
    response_t          rsp;
    logic [FIELD_W-1:0] range_last;
    logic [FIELD_W-1:0] pool_top;
    int                 free_idx;
    int                 hit_idx;
    rsp.status = ST_OK;
    rsp.handle = '0;
    range_last = first + count - 1'b1;
    pool_top   = pool ? {FIELD_W{1'b1}} : FIELD_W'(IO_POOL_LAST);
    free_idx   = -1;
    hit_idx    = -1;
    if (op == OP_RSVD || count == '0 || range_last < first) begin
      rsp.status = ST_INVALID;
    end else if (op == OP_REQUEST) begin
      if (range_last > pool_top) begin
        rsp.status = ST_INVALID;
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_held[i]) begin
            if (slot_pool[i] == pool && !(range_last < slot_first[i] || first > slot_last[i]))
              rsp.status = ST_CONFLICT;
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (rsp.status == ST_OK) begin
          if (free_idx < 0) begin
            rsp.status = ST_FULL;
          end else begin
            slot_held[free_idx]  = 1'b1;
            slot_pool[free_idx]  = pool;
            slot_first[free_idx] = first;
            slot_last[free_idx]  = range_last;
            rsp.handle           = HANDLE_W'(free_idx);
          end
        end
      end
    end else begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (slot_held[i] && slot_pool[i] == pool && slot_first[i] == first &&
            slot_last[i] == range_last)
          hit_idx = i;
      end
      if (hit_idx < 0) begin
        rsp.status = ST_NOT_FOUND;
      end else begin
        rsp.handle = HANDLE_W'(hit_idx);
        if (op == OP_RELEASE) slot_held[hit_idx] = 1'b0;
      end
    end
    return rsp;
  endfunction

  always @(posedge clk) begin
    response_t want;
    status_t   got_status;
    logic [HANDLE_W-1:0] got_handle;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_held[i] = 1'b0;
      expected_responses.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_status = status_t'(out_tdata[2:0]);
        got_handle = out_tdata[3 +: HANDLE_W];
        if (expected_responses.size() == 0) begin
          report_mismatch($sformatf("response with no request pending: status %0d handle %0d",
                                    got_status, got_handle));
        end else begin
          want = expected_responses.pop_front();
          if (got_status !== want.status)
            report_mismatch($sformatf("status mismatch: got %0d, want %0d",
                                      got_status, want.status));
          if (got_handle !== want.handle)
            report_mismatch($sformatf("handle mismatch: got %0d, want %0d",
                                      got_handle, want.handle));
        end
      end
      if (in_tvalid && in_tready)
        expected_responses.push_back(predict_reservation(opcode_t'(in_tuser[1:0]), in_tuser[2],
                                                         in_tdata[FIELD_W-1:0],
                                                         in_tdata[2*FIELD_W-1:FIELD_W]));
    end
    pending_count = expected_responses.size();
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives reserve, release and find requests into the reservation table,
// first a directed set covering the pool edges, bad ranges, a full table
// and conflicts, then random traffic in three handshake pressure phases.
// Checking is done by range_table_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import arrt_pkg::*;

  typedef struct {
    logic               pool;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] count;
  } range_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // range_start, range_count
  logic [IN_USER_W-1:0]  in_tuser = '0;   // opcode, pool_select
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // status, slot_handle, pad

  int fail_count;
  int pending_count;
  int in_idle_pct  = 31;
  int out_idle_pct = 87;

  range_req_t recent_ranges[$];

  address_range_reservation_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  range_table_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // valid drops only when a gap is taken, so it never toggles within one step
  task automatic send_request(input opcode_t op, input logic pool,
                              input logic [FIELD_W-1:0] start, input logic [FIELD_W-1:0] count);
    range_req_t r;
    if ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {count, start};
    in_tuser  <= {pool, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_REQUEST) begin
      r.pool  = pool;
      r.start = start;
      r.count = count;
      recent_ranges.push_back(r);
      if (recent_ranges.size() > 48) void'(recent_ranges.pop_front());
    end
  endtask

  task automatic send_random_request();
    range_req_t r;
    opcode_t    op;
    int         pick;
    int         shape;
    pick  = $urandom_range(99);
    shape = $urandom_range(99);
    op = (pick < 45) ? OP_REQUEST : (pick < 75) ? OP_RELEASE : (pick < 95) ? OP_FIND : OP_RSVD;
    r.pool = 1'($urandom_range(1));
    if (shape < 10) begin
      r.start = $urandom;
      r.count = $urandom;
    end else if (shape < 15) begin
      r.start = $urandom;
      r.count = '0;
    end else if (shape < 20) begin
      r.start = 32'hFFFF_FFFF - $urandom_range(255);
      r.count = $urandom_range(1, 512);
    end else if (shape < 25) begin
      r.start = 32'h0000_FFFF - $urandom_range(63);
      r.count = $urandom_range(1, 256);
    end else if (!r.pool) begin
      r.start = ($urandom_range(31) << 11) + $urandom_range(255);
      r.count = $urandom_range(1, 1024);
    end else begin
      r.start = ($urandom_range(31) << 27) + ($urandom_range(255) << 12);
      r.count = $urandom_range(1, 32'h0100_0000);
    end
    // release and find mostly target ranges that were asked for earlier
    if (op != OP_REQUEST && op != OP_RSVD && recent_ranges.size() > 0 &&
        $urandom_range(99) < 75)
      r = recent_ranges[$urandom_range(recent_ranges.size() - 1)];
    send_request(op, r.pool, r.start, r.count);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_REQUEST, 1'b0, 32'h0000_0000, 32'd1);
    send_request(OP_REQUEST, 1'b0, 32'h0000_FFFF, 32'd1);
    send_request(OP_REQUEST, 1'b0, 32'h0000_FFFF, 32'd2);
    send_request(OP_REQUEST, 1'b1, 32'hFFFF_FFFF, 32'd1);
    send_request(OP_REQUEST, 1'b1, 32'hFFFF_FFFF, 32'd2);
    send_request(OP_REQUEST, 1'b1, 32'h1234_0000, 32'd0);
    send_request(OP_RSVD,    1'b1, 32'h0000_1000, 32'd16);
    send_request(OP_REQUEST, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_FIND,    1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_RELEASE, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_RELEASE, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_FIND,    1'b0, 32'h0000_FFFF, 32'd2);
    send_request(OP_REQUEST, 1'b0, 32'h0000_0000, 32'd1);
    send_request(OP_REQUEST, 1'b1, 32'h0000_0000, 32'd1);
    for (int i = 1; i <= 12; i++)
      send_request(OP_REQUEST, 1'b0, 32'h100 * i, 32'h10);
    send_request(OP_REQUEST, 1'b0, 32'h0000_8000, 32'd4);
    send_request(OP_REQUEST, 1'b0, 32'h0000_0100, 32'd1);
    send_request(OP_RELEASE, 1'b0, 32'h0000_FFFF, 32'd1);

    for (int i = 0; i < 233; i++) send_random_request();
    in_idle_pct  = 87;
    out_idle_pct = 31;
    for (int i = 0; i < 233; i++) send_random_request();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    for (int i = 0; i < 234; i++) send_random_request();
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
